### sv/move_list_promote_to_front_top_defines.svh
// Assertion macros for the move-to-front list block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MOVE_LIST_PROMOTE_TO_FRONT_TOP_DEFINES_SVH
`define MOVE_LIST_PROMOTE_TO_FRONT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MLPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MLPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mlpf_pkg.sv
// Shared types and constants for the move-to-front list block.
// No dependencies; imported by the cell, the pick logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mlpf_pkg;

    localparam int LIST_DEPTH_DEF = 256;
    localparam int KEY_W          = 32;
    localparam int POS_W          = 8;
    localparam int LEN_W          = 9;
    localparam int FROM_W         = 9;
    localparam int MODE_W         = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 3'd0,
        MODE_APPEND  = 3'd1,
        MODE_PROMOTE = 3'd2,
        MODE_PAIR    = 3'd3,
        MODE_READ    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_CMP
    } t_state;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic              cmp;
        logic              load;
        logic              move;
        logic              found;
        logic [FROM_W-1:0] from;
        logic [LEN_W-1:0]  count;
        logic [FROM_W-1:0] load_idx;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  score;
    } t_cell_cmd;

endpackage

`default_nettype wire

### sv/mlpf_cell.sv
// One list slot: holds a key and score, compares against the search key and
// takes its left neighbor's entry on a shift. Depends on mlpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlpf_cell
    import mlpf_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic [KEY_W-1:0] i_prev_key,
    input  wire logic [KEY_W-1:0] i_prev_score,
    input  wire logic             i_span,
    input  wire logic [KEY_W-1:0] i_match_key,
    input  wire logic [KEY_W-1:0] i_match_score,
    output logic      [KEY_W-1:0] o_key,
    output logic      [KEY_W-1:0] o_score,
    output logic                  o_hit
);

    localparam logic [FROM_W-1:0] IDX_V = FROM_W'(IDX);

    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_score, n_score;
    logic             r_hit;
    logic             at_from;
    logic             in_range;

    assign at_from  = (IDX_V == i_cmd.from);
    assign in_range = (IDX_V >= i_cmd.from) && (IDX_V < i_cmd.count);

    // Pick the next entry: append load, insert of the match at the from cell, or shift from the left
    always_comb begin
        n_key   = r_key;
        n_score = r_score;
        if (i_cmd.load && (i_cmd.load_idx == IDX_V)) begin
            n_key   = i_cmd.key;
            n_score = i_cmd.score;
        end else if (i_cmd.move && i_cmd.found && at_from) begin
            n_key   = i_match_key;
            n_score = i_match_score;
        end else if (i_cmd.move && i_span && (IDX_V > i_cmd.from)) begin
            n_key   = i_prev_key;
            n_score = i_prev_score;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_score <= n_score;
    end

    // Latch the compare result for the following move cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.cmp) begin
            r_hit <= in_range && (r_key == i_cmd.key);
        end
    end

    assign o_key   = r_key;
    assign o_score = r_score;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

### sv/mlpf_pick.sv
// First-match isolation over the cells' hit flags: one-hot first hit and the
// span of cells at or below it. Depends on mlpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlpf_pick
    import mlpf_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic [LIST_DEPTH-1:0] i_hits,
    output logic      [LIST_DEPTH-1:0] o_first,
    output logic      [LIST_DEPTH-1:0] o_span,
    output logic                       o_found
);

    logic [LIST_DEPTH-1:0] dec;

    // Borrow ripples up to the lowest hit: xor marks that bit and all below
    assign dec     = i_hits - LIST_DEPTH'(1);
    assign o_found = |i_hits;
    assign o_span  = o_found ? (i_hits ^ dec) : '0;
    assign o_first = i_hits & o_span;

endmodule

`default_nettype wire

### sv/move_list_promote_to_front_top.sv
// Move-to-front list: controller, row of entry cells and match select.
// Depends on mlpf_pkg, mlpf_cell, mlpf_pick and the assertion macro header.
//
//   channel   handshake                  payload
//   request   start / busy               i_mode i_key_a i_key_b i_entry_score i_position
//   result    o_valid (one-cycle strobe) o_found_first o_found_second o_read_key
//                                        o_read_score o_list_length o_overflow
//
// Clear, append, read and unused modes finish at the accept edge, with no busy state.
// Promote compares in all cells at accept and shifts in the next cycle.
// Promote pair steps through compare, shift, compare, shift: key A to i_position, key B after it.
// Reset (synchronous, active low) empties the list; entry contents are not reset.
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

`include "move_list_promote_to_front_top_defines.svh"

module move_list_promote_to_front_top
    import mlpf_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [MODE_W-1:0] i_mode,
    input  wire logic signed [KEY_W-1:0]  i_key_a,
    input  wire logic signed [KEY_W-1:0]  i_key_b,
    input  wire logic signed [KEY_W-1:0]  i_entry_score,
    input  wire logic        [POS_W-1:0]  i_position,
    output logic                          o_valid,
    output logic                          o_found_first,
    output logic                          o_found_second,
    output logic signed      [KEY_W-1:0]  o_read_key,
    output logic signed      [KEY_W-1:0]  o_read_score,
    output logic             [LEN_W-1:0]  o_list_length,
    output logic                          o_overflow
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count;
    logic              r_pair;
    logic              r_pass;
    logic              r_f1;
    logic [KEY_W-1:0]  r_key_b;
    logic [POS_W-1:0]  r_pos;

    logic              r_valid;
    logic              r_found_first;
    logic              r_found_second;
    logic [KEY_W-1:0]  r_read_key;
    logic [KEY_W-1:0]  r_read_score;
    logic [LEN_W-1:0]  r_list_length;
    logic              r_overflow;

    logic              accept;
    logic              is_prom;
    logic              last_move;
    logic [FROM_W-1:0] pos_next;
    t_cell_cmd         cmd;

    logic [KEY_W-1:0]      w_key   [LIST_DEPTH];
    logic [KEY_W-1:0]      w_score [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_hits;
    logic [LIST_DEPTH-1:0] w_first;
    logic [LIST_DEPTH-1:0] w_span;
    logic                  w_found;

    logic [LIST_DEPTH-1:0] rd_sel;
    logic [LIST_DEPTH-1:0] sel_vec;
    logic [KEY_W-1:0]      sel_key;
    logic [KEY_W-1:0]      sel_score;
    logic                  rd_ok;
    logic                  full;

    assign accept    = start && !busy;
    assign is_prom   = (i_mode == MODE_PROMOTE) || (i_mode == MODE_PAIR);
    assign last_move = (r_state == S_MOVE) && (!r_pair || r_pass);
    assign pos_next  = FROM_W'(r_pos) + FROM_W'(1);
    assign full      = (LEN_W'(r_count) == LEN_W'(LIST_DEPTH));
    assign rd_ok     = (FROM_W'(i_position) < FROM_W'(r_count));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && is_prom) n_state = S_MOVE;
            S_MOVE: n_state = (r_pair && !r_pass) ? S_CMP : S_IDLE;
            S_CMP:  n_state = S_MOVE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cell command and handshake outputs per state
    always_comb begin
        cmd          = '0;
        cmd.count    = LEN_W'(r_count);
        cmd.load_idx = FROM_W'(r_count);
        cmd.found    = w_found;
        busy         = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy      = 1'b0;
                cmd.cmp   = accept && is_prom;
                cmd.load  = accept && (i_mode == MODE_APPEND) && !full;
                cmd.key   = i_key_a;
                cmd.score = i_entry_score;
                cmd.from  = (i_mode == MODE_PAIR) ? FROM_W'(i_position) : '0;
            end
            S_MOVE: begin
                cmd.move = 1'b1;
                if (r_pass) begin
                    cmd.from = pos_next;
                end else begin
                    cmd.from = r_pair ? FROM_W'(r_pos) : '0;
                end
            end
            S_CMP: begin
                cmd.cmp  = 1'b1;
                cmd.key  = r_key_b;
                cmd.from = pos_next;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Row of cells, each shifting from its left neighbor
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] prev_key;
        logic [KEY_W-1:0] prev_score;
        if (g == 0) begin : g_head
            assign prev_key   = '0;
            assign prev_score = '0;
        end else begin : g_body
            assign prev_key   = w_key[g-1];
            assign prev_score = w_score[g-1];
        end
        mlpf_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_prev_key    (prev_key),
            .i_prev_score  (prev_score),
            .i_span        (w_span[g]),
            .i_match_key   (sel_key),
            .i_match_score (sel_score),
            .o_key         (w_key[g]),
            .o_score       (w_score[g]),
            .o_hit         (w_hits[g])
        );
    end

    mlpf_pick #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_pick (
        .i_hits  (w_hits),
        .o_first (w_first),
        .o_span  (w_span),
        .o_found (w_found)
    );

    // One-hot select: first match while moving, read index otherwise
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            rd_sel[i] = (FROM_W'(i_position) == FROM_W'(i));
        end
        sel_vec   = (r_state == S_MOVE) ? w_first : rd_sel;
        sel_key   = '0;
        sel_score = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            sel_key   = sel_key   | (sel_vec[i] ? w_key[i]   : '0);
            sel_score = sel_score | (sel_vec[i] ? w_score[i] : '0);
        end
    end

    // Hold request fields and pass state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pair  <= 1'b0;
            r_pass  <= 1'b0;
            r_f1    <= 1'b0;
        end else begin
            if (accept) begin
                r_pair <= (i_mode == MODE_PAIR);
                r_pass <= 1'b0;
                if (i_mode == MODE_CLEAR) begin
                    r_count <= '0;
                end else if ((i_mode == MODE_APPEND) && !full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if ((r_state == S_MOVE) && !r_pass) begin
                r_f1   <= w_found;
                r_pass <= r_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_b <= i_key_b;
            r_pos   <= i_position;
        end
    end

    // Load the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (accept && !is_prom) || last_move;
        end
    end

    // Load the results: flag a dropped append; zero the read fields unless a read is in the live list
    always_ff @(posedge i_clk) begin
        if (accept && !is_prom) begin
            r_found_first  <= 1'b0;
            r_found_second <= 1'b0;
            r_overflow     <= (i_mode == MODE_APPEND) && full;
            r_read_key     <= ((i_mode == MODE_READ) && rd_ok) ? sel_key : '0;
            r_read_score   <= ((i_mode == MODE_READ) && rd_ok) ? sel_score : '0;
            case (i_mode)
                MODE_CLEAR: begin
                    r_list_length <= '0;
                end
                MODE_APPEND: begin
                    r_list_length <= full ? LEN_W'(r_count) : LEN_W'(r_count) + LEN_W'(1);
                end
                default: begin
                    r_list_length <= LEN_W'(r_count);
                end
            endcase
        end else if (last_move) begin
            r_found_first  <= r_pass ? r_f1 : w_found;
            r_found_second <= r_pass ? w_found : 1'b0;
            r_overflow     <= 1'b0;
            r_read_key     <= '0;
            r_read_score   <= '0;
            r_list_length  <= LEN_W'(r_count);
        end
    end

    assign o_valid        = r_valid;
    assign o_found_first  = r_found_first;
    assign o_found_second = r_found_second;
    assign o_read_key     = r_read_key;
    assign o_read_score   = r_read_score;
    assign o_list_length  = r_list_length;
    assign o_overflow     = r_overflow;

    // Checks on controller sequencing and match isolation
    `MLPF_ASSERT_IMP(a_valid_not_busy, i_clk, i_rst_n, o_valid, !busy, "strobe while busy")
    `MLPF_ASSERT_NXT(a_prom_to_move, i_clk, i_rst_n, accept && is_prom, (r_state == S_MOVE) && !o_valid, "promote did not enter move")
    `MLPF_ASSERT_NXT(a_short_done, i_clk, i_rst_n, accept && !is_prom, o_valid && !busy, "single-cycle request gave no result")
    `MLPF_ASSERT_IMP(a_first_onehot, i_clk, i_rst_n, r_state == S_MOVE, $onehot0(w_first), "more than one first match")
    `MLPF_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, LEN_W'(r_count) <= LEN_W'(LIST_DEPTH), "count beyond depth")

endmodule

`default_nettype wire
